// File: src/gps_pkg.sv
package gps_pkg;

   // Field widths of the channels and the control register.
   localparam int GAIN_W        = 32;
   localparam int RATE_W        = 25;
   localparam int FRAC_BITS_DEF = 24;

   // Internal widths: the target scaled by the overshoot factor, and the
   // stage differences that feed the shared multiplier.
   localparam int GM_W   = 34;
   localparam int DIFF_W = 36;

   localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
   localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAIN,
      ST_PULL,
      ST_FIRST,
      ST_DIFF,
      ST_SECOND,
      ST_EMIT
   } gps_state_type;

   // 0.07, 1.07 and 0.0001 rounded to nearest at the given fraction width.
   function automatic longint over_a_q(input int frac);
      return (7 * (longint'(1) << frac) + 50) / 100;
   endfunction

   function automatic longint over_b_q(input int frac);
      return (107 * (longint'(1) << frac) + 50) / 100;
   endfunction

   function automatic longint snap_tol_q(input int frac);
      return ((longint'(1) << frac) + 5000) / 10000;
   endfunction

endpackage

// File: src/gps_req_if.sv
interface gps_req_if;
   import gps_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [GAIN_W-1:0] target_gain;
   logic                     buffer_end;

   modport source (output valid, target_gain, buffer_end, input ready);
   modport sink   (input valid, target_gain, buffer_end, output ready);
endinterface

// File: src/gps_rsp_if.sv
interface gps_rsp_if;
   import gps_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [GAIN_W-1:0] gain_out;
   logic                     ran;

   modport source (output valid, gain_out, ran, input ready);
   modport sink   (input valid, gain_out, ran, output ready);
endinterface

// File: src/gps_serial_mul.sv
// Radix-4 digit-serial multiplier: signed multiplicand times unsigned
// multiplier, two multiplier bits retired per cycle through a shift register.
module gps_serial_mul #(
   parameter int MCAND_W  = gps_pkg::DIFF_W,
   parameter int MPLIER_W = gps_pkg::RATE_W,
   localparam int PROD_W  = MCAND_W + 1 + 2 * ((MPLIER_W + 1) / 2)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [MCAND_W-1:0] mcand,
   input  logic [MPLIER_W-1:0]       mplier,
   output logic                      done,
   output logic signed [PROD_W-1:0]  product
);
   localparam int NDIG  = (MPLIER_W + 1) / 2;
   localparam int LO_W  = 2 * NDIG;
   localparam int HI_W  = MCAND_W + 1;
   localparam int M3_W  = MCAND_W + 2;
   localparam int SUM_W = MCAND_W + 3;
   localparam int CNT_W = $clog2(NDIG + 1);

   logic signed [MCAND_W-1:0] m1_ff, m1_in;
   logic signed [M3_W-1:0]    m3_ff, m3_in;
   logic signed [HI_W-1:0]    hi_ff, hi_in;
   logic [LO_W-1:0]           lo_ff, lo_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic signed [SUM_W-1:0]   pp;
   logic signed [SUM_W-1:0]   sum;

   always_comb begin
      unique case (lo_ff[1:0])
         2'd0: pp = '0;
         2'd1: pp = SUM_W'(m1_ff);
         2'd2: pp = SUM_W'(m1_ff) <<< 1;
         2'd3: pp = SUM_W'(m3_ff);
         default: pp = '0;
      endcase
      sum = SUM_W'(hi_ff) + pp;
   end

   always_comb begin
      m1_in   = m1_ff;
      m3_in   = m3_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // load operands, precompute three times the multiplicand
         m1_in   = mcand;
         m3_in   = M3_W'(mcand) + (M3_W'(mcand) <<< 1);
         hi_in   = '0;
         lo_in   = LO_W'(mplier);
         cnt_in  = CNT_W'(NDIG);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // add one digit's partial product, shift two bits into the low word
         hi_in  = sum[SUM_W-1:2];
         lo_in  = {sum[1:0], lo_ff[LO_W-1:2]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      m1_ff <= m1_in;
      m3_ff <= m3_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("multiplier started while busy");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("multiplier done while still busy");

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("multiplier busy with empty digit count");

endmodule

// File: src/two_pole_gain_smoother.sv
// Channel    Dir  Payload                         Transfer
// ---------  ---  ------------------------------  ----------------------
// req_chan   in   target_gain[31:0], buffer_end   valid && ready
// rsp_chan   out  gain_out[31:0], ran             valid && ready
// csr        in   csr_write_data[24:0]            csr_write_enable high
//
// One frame in a buffer that runs uses the multiplier for 0.07*s2, w*d1 and
// w*d2 in turn; the first frame of such a buffer forms 1.07*T before these.
// D is the digit count (M+1)/2 of the radix-4 serial multiplier,
// M = max(25, FRAC_BITS+1), and each multiply steps through its D digits.
// A skipped buffer's frame emits with no multiply. The next frame transfers in the
// cycle after a result is loaded into the output register.
// Reset clears both stages, the held target and the buffer flags. A stalled
// result stays in the output register; a finished frame waits only if that
// register is still full.
module two_pole_gain_smoother #(
   parameter int FRAC_BITS = gps_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   gps_req_if.sink                     req_chan,
   gps_rsp_if.source                   rsp_chan,
   input  logic                        csr_write_enable,
   input  logic [gps_pkg::RATE_W-1:0]  csr_write_data
);
   import gps_pkg::*;

   // Multiplier widths: the multiplier operand must hold w and the 1.07 constant.
   localparam int M_W   = (RATE_W > FRAC_BITS + 1) ? RATE_W : FRAC_BITS + 1;
   localparam int LO_W  = 2 * ((M_W + 1) / 2);
   localparam int P_W   = DIFF_W + 1 + LO_W;
   localparam int Q_W   = P_W - FRAC_BITS;
   localparam int RS_W  = Q_W + 1;
   localparam int SUM_W = RS_W + 1;

   localparam logic [M_W-1:0] OVER_A_Q = M_W'(over_a_q(FRAC_BITS));
   localparam logic [M_W-1:0] OVER_B_Q = M_W'(over_b_q(FRAC_BITS));
   localparam logic signed [GAIN_W:0] SNAP_TOL_Q = (GAIN_W + 1)'(snap_tol_q(FRAC_BITS));

   gps_state_type state_ff, state_in;

   // filter state
   logic signed [GAIN_W-1:0] s1_ff, s1_in;
   logic signed [GAIN_W-1:0] s2_ff, s2_in;
   logic signed [GAIN_W-1:0] held_ff, held_in;
   logic signed [GM_W-1:0]   gm_ff, gm_in;
   logic                     mid_ff, mid_in;
   logic                     skip_ff, skip_in;
   logic                     last_ff, last_in;
   logic                     ran_ff, ran_in;
   logic [RATE_W-1:0]        rate_ff, rate_in;

   // output register
   logic                     out_valid_ff, out_valid_in;
   logic signed [GAIN_W-1:0] out_gain_ff, out_gain_in;
   logic                     out_ran_ff, out_ran_in;

   // shared multiplier
   logic                     mul_start;
   logic signed [DIFF_W-1:0] mul_mcand;
   logic [M_W-1:0]           mul_mplier;
   logic                     mul_done;
   logic signed [P_W-1:0]    mul_product;

   logic signed [Q_W-1:0]    prod_q;
   logic signed [RS_W-1:0]   rs_val;
   logic signed [SUM_W-1:0]  s1_sum;
   logic signed [SUM_W-1:0]  s2_sum;
   logic signed [DIFF_W-1:0] d1;
   logic signed [DIFF_W-1:0] d2;
   logic signed [GAIN_W:0]   gap;
   logic                     snap_hit;
   logic                     skip_now;
   logic                     req_take;
   logic                     rsp_take;

   function automatic logic signed [GAIN_W-1:0] sat_gain(input logic signed [SUM_W-1:0] v);
      logic fits;
      fits = (v[SUM_W-1:GAIN_W-1] == {(SUM_W - GAIN_W + 1){v[GAIN_W-1]}});
      if (fits)
         return v[GAIN_W-1:0];
      else if (v[SUM_W-1])
         return GAIN_MIN;
      else
         return GAIN_MAX;
   endfunction

   gps_serial_mul #(
      .MCAND_W  (DIFF_W),
      .MPLIER_W (M_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .done    (mul_done),
      .product (mul_product)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_take       = out_valid_ff && rsp_chan.ready;

   // Round the product back to FRAC_BITS fraction bits, ties up: adding half an
   // LSB carries into the kept part exactly when the first dropped bit is set.
   assign prod_q = mul_product[P_W-1:FRAC_BITS];
   assign rs_val = RS_W'(prod_q) + RS_W'(mul_product[FRAC_BITS-1]);

   assign s1_sum = SUM_W'(s1_ff) + SUM_W'(rs_val);
   assign s2_sum = SUM_W'(s2_ff) + SUM_W'(rs_val);

   // drive of the first stage: 1.07*T - s1 - 0.07*s2
   assign d1 = DIFF_W'(gm_ff) - DIFF_W'(s1_ff) - DIFF_W'(rs_val);
   // drive of the second stage: s1 - s2
   assign d2 = DIFF_W'(s1_ff) - DIFF_W'(s2_ff);

   // end-of-buffer snap window: |T - s2| < tolerance
   assign gap      = (GAIN_W + 1)'(held_ff) - (GAIN_W + 1)'(s2_ff);
   assign snap_hit = (gap < SNAP_TOL_Q) && (gap > -SNAP_TOL_Q);

   // On the first frame of a buffer the decision to skip comes from the new target.
   assign skip_now = mid_ff ? skip_ff : (s2_ff == req_chan.target_gain);

   assign rate_in = csr_write_enable ? csr_write_data : rate_ff;

   always_comb begin
      state_in     = state_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      held_in      = held_ff;
      gm_in        = gm_ff;
      mid_in       = mid_ff;
      skip_in      = skip_ff;
      last_in      = last_ff;
      ran_in       = ran_ff;
      out_valid_in = out_valid_ff;
      out_gain_in  = out_gain_ff;
      out_ran_in   = out_ran_ff;
      mul_start    = 1'b0;
      mul_mcand    = '0;
      mul_mplier   = '0;

      // drop the result once the sink takes it
      if (rsp_take)
         out_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               last_in = req_chan.buffer_end;
               if (!mid_ff) begin
                  // first frame: latch the target and decide on the whole buffer
                  held_in = req_chan.target_gain;
                  mid_in  = 1'b1;
                  skip_in = skip_now;
               end
               if (skip_now) begin
                  ran_in   = 1'b0;
                  state_in = ST_EMIT;
               end else if (!mid_ff) begin
                  // scaled target changes only with the target: form it once per buffer
                  ran_in     = 1'b1;
                  mul_start  = 1'b1;
                  mul_mcand  = DIFF_W'(req_chan.target_gain);
                  mul_mplier = OVER_B_Q;
                  state_in   = ST_GAIN;
               end else begin
                  ran_in     = 1'b1;
                  mul_start  = 1'b1;
                  mul_mcand  = DIFF_W'(s2_ff);
                  mul_mplier = OVER_A_Q;
                  state_in   = ST_PULL;
               end
            end
         end
         ST_GAIN: begin
            if (mul_done) begin
               gm_in      = GM_W'(rs_val);
               mul_start  = 1'b1;
               mul_mcand  = DIFF_W'(s2_ff);
               mul_mplier = OVER_A_Q;
               state_in   = ST_PULL;
            end
         end
         ST_PULL: begin
            // overshoot term ready: start w * d1
            if (mul_done) begin
               mul_start  = 1'b1;
               mul_mcand  = d1;
               mul_mplier = M_W'(rate_ff);
               state_in   = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (mul_done) begin
               s1_in    = sat_gain(s1_sum);
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            mul_start  = 1'b1;
            mul_mcand  = d2;
            mul_mplier = M_W'(rate_ff);
            state_in   = ST_SECOND;
         end
         ST_SECOND: begin
            if (mul_done) begin
               s2_in    = sat_gain(s2_sum);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free; the result is s2 before the snap
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_gain_in  = s2_ff;
               out_ran_in   = ran_ff;
               if (last_ff) begin
                  mid_in  = 1'b0;
                  skip_in = 1'b0;
                  if (ran_ff && snap_hit)
                     s2_in = held_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_ff        <= '0;
         s2_ff        <= '0;
         held_ff      <= '0;
         mid_ff       <= 1'b0;
         skip_ff      <= 1'b0;
         last_ff      <= 1'b0;
         ran_ff       <= 1'b0;
         rate_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         held_ff      <= held_in;
         mid_ff       <= mid_in;
         skip_ff      <= skip_in;
         last_ff      <= last_in;
         ran_ff       <= ran_in;
         rate_ff      <= rate_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gm_ff       <= gm_in;
      out_gain_ff <= out_gain_in;
      out_ran_ff  <= out_ran_in;
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.gain_out = out_gain_ff;
   assign rsp_chan.ran      = out_ran_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_GAIN || state_ff == ST_PULL ||
                    state_ff == ST_FIRST || state_ff == ST_SECOND))
      else $error("multiplier result arrived outside a wait state");

   a_ran_vs_skip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (ran_ff != skip_ff))
      else $error("ran flag disagrees with buffer skip flag");

   a_skip_in_buffer: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> mid_ff)
      else $error("skip flag set outside a buffer");

   a_s2_writer: assert property (@(posedge clock) disable iff (reset)
      !$stable(s2_ff) |-> $past(state_ff == ST_SECOND || state_ff == ST_EMIT))
      else $error("second stage changed outside its update or snap");

endmodule
